### hw/rtl/nrx_pkg.sv
package nrx_pkg;

    localparam int QUEUE_SLOTS_DEF      = 8;
    localparam int MAX_PACKET_BYTES_DEF = 256;

    localparam int LEN_W     = 9;
    localparam int BYTE_W    = 8;
    localparam int STATUS_W  = 3;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    localparam logic [PADDR_W-1:0] ADDR_NODE_INDEX = 3'd0;

    localparam logic [STATUS_W-1:0] ST_DIRECT   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DECODED  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_MISMATCH = 3'd3;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd4;

    typedef struct packed {
        logic [7:0]       destination;
        logic             from_relay;
        logic             is_coded;
        logic [LEN_W-1:0] packet_length;
        logic [7:0]       data_byte;
        logic             last_byte;
    } pkt_t;

    typedef struct packed {
        logic [7:0]          out_byte;
        logic [STATUS_W-1:0] status;
        logic                out_last;
    } res_t;

    // what the control stage hands to the result stage for one accepted byte
    typedef struct packed {
        logic                emit;
        logic                decode;
        logic                no_kept;
        logic [STATUS_W-1:0] status;
        logic [BYTE_W-1:0]   data;
        logic                last;
    } issue_t;

endpackage

### hw/rtl/nrx_store.sv
module nrx_store #(
    parameter int DEPTH  = nrx_pkg::QUEUE_SLOTS_DEF * nrx_pkg::MAX_PACKET_BYTES_DEF,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [ADDR_W-1:0]         waddr,
    input  logic [nrx_pkg::BYTE_W-1:0] wdata,
    input  logic                      re,
    input  logic [ADDR_W-1:0]         raddr,
    output logic [nrx_pkg::BYTE_W-1:0] rdata
);

    logic [nrx_pkg::BYTE_W-1:0] mem [DEPTH];
    logic [nrx_pkg::BYTE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/nrx_ctrl.sv
module nrx_ctrl #(
    parameter int QUEUE_SLOTS      = nrx_pkg::QUEUE_SLOTS_DEF,
    parameter int MAX_PACKET_BYTES = nrx_pkg::MAX_PACKET_BYTES_DEF,
    parameter int ADDR_W           = (QUEUE_SLOTS * MAX_PACKET_BYTES > 1) ?
                                     $clog2(QUEUE_SLOTS * MAX_PACKET_BYTES) : 1
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       accept,
    input  nrx_pkg::pkt_t              pkt,
    input  logic [7:0]                 node_index,
    output nrx_pkg::issue_t            issue,
    output logic                       st_we,
    output logic [ADDR_W-1:0]          st_waddr,
    output logic [nrx_pkg::BYTE_W-1:0] st_wdata,
    output logic                       st_re,
    output logic [ADDR_W-1:0]          st_raddr
);

    localparam int SLOT_W = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
    localparam int CNT_W  = $clog2(QUEUE_SLOTS + 1);
    localparam int OFF_W  = $clog2(MAX_PACKET_BYTES + 1);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(QUEUE_SLOTS - 1);
    localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(QUEUE_SLOTS);
    localparam logic [OFF_W-1:0]  OFF_LIMIT = OFF_W'(MAX_PACKET_BYTES);
    localparam logic [ADDR_W-1:0] SLOT_SPAN = ADDR_W'(MAX_PACKET_BYTES);

    typedef enum logic [2:0] {
        V_START,
        V_DIRECT,
        V_STORE,
        V_DECODE,
        V_OVERFLOW,
        V_EMPTY,
        V_MISMATCH,
        V_SILENT
    } verdict_t;

    verdict_t                   verdict_reg, verdict_next, verdict;
    logic [SLOT_W-1:0]          oldest_reg, oldest_next;
    logic [SLOT_W-1:0]          newest_reg, newest_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [OFF_W-1:0]           offset_reg, offset_next;
    logic [nrx_pkg::LEN_W-1:0]  head_len_reg;
    logic [nrx_pkg::LEN_W-1:0]  len_mem [QUEUE_SLOTS];
    logic                       len_we;
    logic                       in_range;
    logic [ADDR_W-1:0]          off_a;

    always_comb
    begin
        if (verdict_reg == V_START)
        begin
            priority if (pkt.destination == node_index)
                verdict = V_DIRECT;
            else if (!pkt.from_relay)
                verdict = (count_reg >= FULL_CNT) ? V_OVERFLOW : V_STORE;
            else if (pkt.is_coded)
            begin
                if (count_reg == '0)
                    verdict = V_EMPTY;
                else if (head_len_reg != pkt.packet_length)
                    verdict = V_MISMATCH;
                else
                    verdict = V_DECODE;
            end
            else
                verdict = V_SILENT;
        end
        else
        begin
            verdict = verdict_reg;
        end
    end

    assign in_range = offset_reg < OFF_LIMIT;
    assign off_a    = ADDR_W'(offset_reg);
    assign len_we   = accept && (verdict_reg == V_START) && (verdict == V_STORE);

    assign st_we    = accept && (verdict == V_STORE) && in_range;
    assign st_waddr = ADDR_W'(newest_reg) * SLOT_SPAN + off_a;
    assign st_wdata = pkt.data_byte;
    assign st_re    = accept && (verdict == V_DECODE);
    assign st_raddr = ADDR_W'(oldest_reg) * SLOT_SPAN + off_a;

    always_comb
    begin
        issue.decode  = 1'b0;
        issue.no_kept = !in_range;
        issue.data    = '0;
        issue.last    = pkt.last_byte;
        issue.emit    = 1'b1;
        issue.status  = nrx_pkg::ST_DIRECT;
        unique case (verdict)
            V_DIRECT:
            begin
                issue.data = pkt.data_byte;
            end
            V_DECODE:
            begin
                issue.decode = 1'b1;
                issue.data   = pkt.data_byte;
                issue.status = nrx_pkg::ST_DECODED;
            end
            V_EMPTY:    issue.status = nrx_pkg::ST_EMPTY;
            V_MISMATCH: issue.status = nrx_pkg::ST_MISMATCH;
            V_OVERFLOW:
            begin
                issue.status = nrx_pkg::ST_OVERFLOW;
                issue.emit   = pkt.last_byte;
            end
            default:    issue.emit = 1'b0;
        endcase
    end

    always_comb
    begin
        verdict_next = verdict_reg;
        oldest_next  = oldest_reg;
        newest_next  = newest_reg;
        count_next   = count_reg;
        offset_next  = offset_reg;
        if (accept)
        begin
            verdict_next = verdict;
            if (pkt.last_byte)
            begin
                verdict_next = V_START;
                offset_next  = '0;
                if (verdict == V_STORE)
                begin
                    newest_next = (newest_reg == LAST_SLOT) ? '0 : newest_reg + 1'b1;
                    count_next  = count_reg + 1'b1;
                end
                else if (verdict == V_DECODE)
                begin
                    oldest_next = (oldest_reg == LAST_SLOT) ? '0 : oldest_reg + 1'b1;
                    count_next  = count_reg - 1'b1;
                end
            end
            else if (in_range)
            begin
                offset_next = offset_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            verdict_reg <= V_START;
            oldest_reg  <= '0;
            newest_reg  <= '0;
            count_reg   <= '0;
            offset_reg  <= '0;
        end
        else
        begin
            verdict_reg <= verdict_next;
            oldest_reg  <= oldest_next;
            newest_reg  <= newest_next;
            count_reg   <= count_next;
            offset_reg  <= offset_next;
        end
    end

    // slot lengths; head_len_reg follows the oldest slot, forwarding a same-edge write
    always_ff @(posedge clk)
    begin
        if (len_we)
        begin
            len_mem[newest_reg] <= pkt.packet_length;
        end
        if (len_we && (newest_reg == oldest_next))
            head_len_reg <= pkt.packet_length;
        else
            head_len_reg <= len_mem[oldest_next];
    end

endmodule

### hw/rtl/nrx_out.sv
module nrx_out (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       accept,
    input  nrx_pkg::issue_t            issue,
    input  logic [nrx_pkg::BYTE_W-1:0] kept,
    output logic                       busy,
    output logic                       res_valid,
    input  logic                       res_stall,
    output nrx_pkg::res_t              res
);

    logic            s1_valid_reg, s1_valid_next;
    nrx_pkg::issue_t s1_reg;
    logic            out_valid_reg, out_valid_next;
    nrx_pkg::res_t   out_reg, out_next;
    logic            advance;

    assign advance = !out_valid_reg || !res_stall;
    assign busy    = s1_valid_reg && !advance;

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = s1_valid_reg;
            s1_valid_next  = 1'b0;
        end
        if (accept)
        begin
            s1_valid_next = issue.emit;
        end
        out_next.out_byte = s1_reg.data ^
                            ((s1_reg.decode && !s1_reg.no_kept) ? kept : '0);
        out_next.status   = s1_reg.status;
        out_next.out_last = s1_reg.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= issue;
        end
        if (advance && s1_valid_reg)
        begin
            out_reg <= out_next;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

endmodule

### hw/rtl/xor_network_coding_receiver.sv
// A result is registered first in s1_reg and then in out_reg before it is offered as a transfer.
// Throughput: one byte per cycle while pkt_stall is low; bytes that give no result pass at the same rate.
// The packet store is a single-port-write memory with one registered read per cycle.
// Reset clears node_index, the slot pointers, the stored count and the packet tracking;
// the packet store and slot lengths hold no defined value until written.
module xor_network_coding_receiver #(
    parameter int QUEUE_SLOTS      = nrx_pkg::QUEUE_SLOTS_DEF,
    parameter int MAX_PACKET_BYTES = nrx_pkg::MAX_PACKET_BYTES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        pkt_valid,
    output logic                        pkt_stall,
    input  nrx_pkg::pkt_t               pkt,
    output logic                        res_valid,
    input  logic                        res_stall,
    output nrx_pkg::res_t               res,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [nrx_pkg::PADDR_W-1:0] paddr,
    input  logic [nrx_pkg::PDATA_W-1:0] pwdata,
    output logic [nrx_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);

    localparam int DEPTH  = QUEUE_SLOTS * MAX_PACKET_BYTES;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [7:0]                 node_index_reg;
    logic                       accept;
    logic                       busy;
    nrx_pkg::issue_t            issue;
    logic                       st_we, st_re;
    logic [ADDR_W-1:0]          st_waddr, st_raddr;
    logic [nrx_pkg::BYTE_W-1:0] st_wdata, st_rdata;

    assign pready    = 1'b1;
    assign pkt_stall = busy;
    assign accept    = pkt_valid && !busy;
    assign prdata    = (paddr == nrx_pkg::ADDR_NODE_INDEX) ?
                       nrx_pkg::PDATA_W'(node_index_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_index_reg <= '0;
        end
        else if (psel && penable && pwrite && pready && (paddr == nrx_pkg::ADDR_NODE_INDEX))
        begin
            node_index_reg <= pwdata[7:0];
        end
    end

    nrx_ctrl #(
        .QUEUE_SLOTS      (QUEUE_SLOTS),
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES),
        .ADDR_W           (ADDR_W)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .pkt        (pkt),
        .node_index (node_index_reg),
        .issue      (issue),
        .st_we      (st_we),
        .st_waddr   (st_waddr),
        .st_wdata   (st_wdata),
        .st_re      (st_re),
        .st_raddr   (st_raddr)
    );

    nrx_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .re    (st_re),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    nrx_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .issue     (issue),
        .kept      (st_rdata),
        .busy      (busy),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

endmodule

### hw/rtl/nrx_checker.sv
module nrx_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          pkt_stall,
    input logic          res_valid,
    input logic          res_stall,
    input nrx_pkg::res_t res
);

    // hold a stalled result
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res))
        else $error("result changed while stalled");

    // input backs up only behind a stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        pkt_stall |-> res_valid && res_stall)
        else $error("input stalled without output backpressure");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res.status <= nrx_pkg::ST_OVERFLOW)
        else $error("status out of range");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res.status == nrx_pkg::ST_EMPTY || res.status == nrx_pkg::ST_MISMATCH
                      || res.status == nrx_pkg::ST_OVERFLOW) |-> res.out_byte == '0)
        else $error("error status with nonzero byte");

    a_overflow_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.status == nrx_pkg::ST_OVERFLOW |-> res.out_last)
        else $error("overflow result not on last byte");

endmodule

bind xor_network_coding_receiver nrx_checker u_nrx_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .pkt_stall (pkt_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
);

### tb/xor_network_coding_receiver_tb.sv
`timescale 1ns / 100ps

module xor_network_coding_receiver_tb;

    localparam int SLOTS = nrx_pkg::QUEUE_SLOTS_DEF;
    localparam int MAXB  = nrx_pkg::MAX_PACKET_BYTES_DEF;

    // register 4 does not exist; writes to it must leave node_index alone
    localparam logic [nrx_pkg::PADDR_W-1:0] ADDR_SPARE = 3'd4;

    typedef enum logic [2:0] {
        PK_IDLE,
        PK_DELIVER,
        PK_KEEP,
        PK_DECODE,
        PK_FULL,
        PK_NO_KEPT,
        PK_BAD_LEN,
        PK_DROP
    } pkt_verdict_t;

    logic                         clk       = 1'b0;
    logic                         rst_n     = 1'b0;
    logic                         pkt_valid = 1'b0;
    logic                         pkt_stall;
    nrx_pkg::pkt_t                pkt       = '0;
    logic                         res_valid;
    logic                         res_stall = 1'b0;
    nrx_pkg::res_t                res;
    logic                         psel      = 1'b0;
    logic                         penable   = 1'b0;
    logic                         pwrite    = 1'b0;
    logic [nrx_pkg::PADDR_W-1:0]  paddr     = '0;
    logic [nrx_pkg::PDATA_W-1:0]  pwdata    = '0;
    logic [nrx_pkg::PDATA_W-1:0]  prdata;
    logic                         pready;

    // decoder state as the testbench sees it
    logic [7:0]   my_node = 8'h00;
    logic [7:0]   kept_bytes [SLOTS][MAXB];
    logic [8:0]   kept_len [SLOTS] = '{default: 9'd0};
    int unsigned  kept_depth [SLOTS] = '{default: 0};
    int unsigned  head_slot = 0;
    int unsigned  tail_slot = 0;
    int unsigned  kept_count = 0;
    int unsigned  cur_offset = 0;
    pkt_verdict_t cur_verdict = PK_IDLE;

    nrx_pkg::res_t expected_results [$];
    int unsigned  mismatch_count = 0;
    int unsigned  bytes_sent = 0;
    int unsigned  results_seen = 0;
    int unsigned  status_seen [5] = '{default: 0};
    logic         steady = 1'b0;
    logic         hold_results = 1'b0;

    xor_network_coding_receiver dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pkt_valid (pkt_valid),
        .pkt_stall (pkt_stall),
        .pkt       (pkt),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("xor_network_coding_receiver regression: fail");
        $finish;
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $time, what);
        mismatch_count++;
    endtask

    function automatic int unsigned next_slot(input int unsigned s);
        return (s + 1 >= SLOTS) ? 0 : s + 1;
    endfunction

    function automatic void push_result(input logic [7:0] b,
                                        input logic [nrx_pkg::STATUS_W-1:0] st,
                                        input logic last);
        nrx_pkg::res_t r;
        r.out_byte = b;
        r.status   = st;
        r.out_last = last;
        expected_results.push_back(r);
    endfunction

    // advance the decoder state by one accepted byte and queue what it yields
    function automatic void predict_byte(input nrx_pkg::pkt_t b);
        pkt_verdict_t v;
        int unsigned  off;
        logic [7:0]   kept;
        off = cur_offset;
        if (cur_verdict == PK_IDLE)
        begin
            if (b.destination == my_node)
                v = PK_DELIVER;
            else if (!b.from_relay)
            begin
                if (kept_count >= SLOTS)
                    v = PK_FULL;
                else
                begin
                    v = PK_KEEP;
                    kept_len[tail_slot] = b.packet_length;
                end
            end
            else if (b.is_coded)
            begin
                if (kept_count == 0)
                    v = PK_NO_KEPT;
                else if (kept_len[head_slot] != b.packet_length)
                    v = PK_BAD_LEN;
                else
                    v = PK_DECODE;
            end
            else
                v = PK_DROP;
            cur_verdict = v;
        end
        else
            v = cur_verdict;

        case (v)
            PK_DELIVER: push_result(b.data_byte, nrx_pkg::ST_DIRECT, b.last_byte);
            PK_KEEP:
            begin
                if (off < MAXB)
                begin
                    kept_bytes[tail_slot][off] = b.data_byte;
                    if (off + 1 > kept_depth[tail_slot])
                        kept_depth[tail_slot] = off + 1;
                end
                if (b.last_byte)
                begin
                    tail_slot = next_slot(tail_slot);
                    kept_count++;
                end
            end
            PK_DECODE:
            begin
                kept = (off < MAXB) ? kept_bytes[head_slot][off] : 8'h00;
                push_result(kept ^ b.data_byte, nrx_pkg::ST_DECODED, b.last_byte);
                if (b.last_byte)
                begin
                    head_slot = next_slot(head_slot);
                    kept_count--;
                end
            end
            PK_NO_KEPT: push_result(8'h00, nrx_pkg::ST_EMPTY, b.last_byte);
            PK_BAD_LEN: push_result(8'h00, nrx_pkg::ST_MISMATCH, b.last_byte);
            PK_FULL:
            begin
                if (b.last_byte)
                    push_result(8'h00, nrx_pkg::ST_OVERFLOW, 1'b1);
            end
            default: ;
        endcase

        if (b.last_byte)
        begin
            cur_offset  = 0;
            cur_verdict = PK_IDLE;
        end
        else if (off < MAXB)
            cur_offset = off + 1;
    endfunction

    always @(posedge clk)
        res_stall <= hold_results || (!steady && ($urandom_range(0, 99) < 12));

    always @(posedge clk)
    begin : check_results
        nrx_pkg::res_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            results_seen++;
            if (res.status < 5)
                status_seen[res.status]++;
            if (expected_results.size() == 0)
                report_mismatch($sformatf("result %02h status %0d with nothing expected",
                                          res.out_byte, res.status));
            else
            begin
                want = expected_results.pop_front();
                if (res.out_byte !== want.out_byte)
                    report_mismatch($sformatf("out_byte %02h, expected %02h",
                                              res.out_byte, want.out_byte));
                if (res.status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              res.status, want.status));
                if (res.out_last !== want.out_last)
                    report_mismatch($sformatf("out_last %0b, expected %0b",
                                              res.out_last, want.out_last));
            end
        end
    end

    task automatic apb_write(input logic [nrx_pkg::PADDR_W-1:0] addr,
                             input logic [nrx_pkg::PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (addr == nrx_pkg::ADDR_NODE_INDEX)
            my_node = data[7:0];
    endtask

    task automatic check_node_readback;
        logic [nrx_pkg::PDATA_W-1:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= nrx_pkg::ADDR_NODE_INDEX;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got[7:0] !== my_node)
            report_mismatch($sformatf("node_index read %02h, expected %02h", got[7:0], my_node));
    endtask

    // one byte transfer, with random idle cycles ahead of it
    task automatic send_byte(input nrx_pkg::pkt_t b);
        while (!steady && ($urandom_range(0, 99) < 12))
        begin
            pkt_valid <= 1'b0;
            @(posedge clk);
        end
        pkt       <= b;
        pkt_valid <= 1'b1;
        do
            @(posedge clk);
        while (pkt_stall);
        predict_byte(b);
        bytes_sent++;
    endtask

    task automatic send_packet(input logic [7:0] dest, input logic relay, input logic coded,
                               input logic [8:0] len, input int unsigned nbytes,
                               input int fill = -1, input bit noisy = 1'b0);
        nrx_pkg::pkt_t b;
        int unsigned   n;
        n = nbytes;
        // a decode must never read a store entry that was never written
        if (dest != my_node && relay && coded && kept_count != 0 && kept_len[head_slot] == len)
        begin
            if (kept_depth[head_slot] < MAXB && n > kept_depth[head_slot])
                n = kept_depth[head_slot];
        end
        for (int k = 0; k < n; k++)
        begin
            b.destination   = dest;
            b.from_relay    = relay;
            b.is_coded      = coded;
            b.packet_length = len;
            if (k > 0 && noisy)
            begin
                b.destination   = 8'($urandom);
                b.from_relay    = 1'($urandom);
                b.is_coded      = 1'($urandom);
                b.packet_length = 9'($urandom_range(1, 256));
            end
            b.data_byte = (fill < 0) ? 8'($urandom) : 8'(fill);
            b.last_byte = (k == n - 1);
            send_byte(b);
        end
    endtask

    // hold the sender until every expected result is back, then let the pipe empty
    task automatic settle_block;
        pkt_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [7:0] other_node;
        logic [7:0] d;
        d = 8'($urandom);
        return (d == my_node) ? ~d : d;
    endfunction

    task automatic random_traffic(input int unsigned n_items);
        int unsigned target;
        int unsigned pick;
        int unsigned nbytes;
        logic [8:0]  len;
        target = bytes_sent + n_items;
        while (bytes_sent < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 1)
                len = 9'd256;
            else if (pick < 3)
                len = 9'($urandom_range(9, 255));
            else
                len = 9'($urandom_range(1, 8));
            nbytes = len;
            if ($urandom_range(0, 99) < 8)
                nbytes = $urandom_range(1, 8);
            pick = $urandom_range(0, 99);
            if (pick < 20)
                send_packet(my_node, 1'($urandom), 1'($urandom), len, nbytes, -1,
                            $urandom_range(0, 9) == 0);
            else if (pick < 50)
                send_packet(other_node(), 1'b0, 1'($urandom), len, nbytes, -1,
                            $urandom_range(0, 9) == 0);
            else if (pick < 78)
            begin
                if (kept_count != 0)
                begin
                    len = kept_len[head_slot];
                    nbytes = ($urandom_range(0, 99) < 8) ? $urandom_range(1, 8) : len;
                end
                send_packet(other_node(), 1'b1, 1'b1, len, nbytes, -1,
                            $urandom_range(0, 9) == 0);
            end
            else if (pick < 86)
                send_packet(other_node(), 1'b1, 1'b1, len, nbytes);
            else if (pick < 94)
                send_packet(other_node(), 1'b1, 1'b0, len, nbytes);
            else
                send_packet(8'($urandom), 1'($urandom), 1'($urandom), len, nbytes, -1,
                            1'($urandom));
        end
    endtask

    task automatic test_register_access;
        check_node_readback();
        apb_write(nrx_pkg::ADDR_NODE_INDEX, {24'($urandom), 8'hC3});
        check_node_readback();
        apb_write(ADDR_SPARE, $urandom);
        check_node_readback();
    endtask

    task automatic test_directed_cases;
        settle_block();
        apb_write(nrx_pkg::ADDR_NODE_INDEX, {24'($urandom), 8'h3C});
        send_packet(my_node, 1'b1, 1'b1, 9'd1, 1, 8'hFF);
        // coded relay packet with nothing stored
        send_packet(8'h00, 1'b1, 1'b1, 9'd2, 2, 8'h00);
        send_packet(8'hFF, 1'b0, 1'b0, 9'd3, 3);
        // coded relay packet whose length disagrees with the oldest slot
        send_packet(8'h01, 1'b1, 1'b1, 9'd2, 2);
        send_packet(8'h80, 1'b1, 1'b1, 9'd3, 3);
        // uncoded relay packet for another node: no result
        send_packet(8'h7E, 1'b1, 1'b0, 9'd2, 2);
        // later header fields must be ignored
        send_packet(8'h11, 1'b0, 1'b1, 9'd2, 2, -1, 1'b1);
        repeat (7)
            send_packet(other_node(), 1'b0, 1'b0, 9'd1, 1);
        // store is full now
        send_packet(8'h22, 1'b0, 1'b0, 9'd2, 2);
        settle_block();
    endtask

    task automatic test_long_packets;
        while (kept_count != 0)
            send_packet(~my_node, 1'b1, 1'b1, kept_len[head_slot], kept_len[head_slot]);
        // overlong packets: bytes past the slot size are dropped, then XORed with zero
        send_packet(~my_node, 1'b0, 1'b0, 9'd256, 300);
        send_packet(~my_node, 1'b1, 1'b1, 9'd256, 260);
        settle_block();
    endtask

    task automatic test_node_settings;
        logic [7:0] node_values [4];
        node_values = '{8'h00, 8'hFF, 8'($urandom), 8'($urandom)};
        for (int i = 0; i < 4; i++)
        begin
            apb_write(nrx_pkg::ADDR_NODE_INDEX, {24'($urandom), node_values[i]});
            check_node_readback();
            steady <= (i == 2);
            random_traffic(175);
            steady <= 1'b0;
            settle_block();
        end
    endtask

    task automatic test_backpressure;
        steady <= 1'b1;
        fork
            begin
                hold_results <= 1'b1;
                repeat (200) @(posedge clk);
                hold_results <= 1'b0;
            end
            send_packet(my_node, 1'b0, 1'b0, 9'd64, 64);
        join
        steady <= 1'b0;
        settle_block();
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_register_access();
        test_directed_cases();
        test_long_packets();
        test_node_settings();
        test_backpressure();
        settle_block();
        repeat (8) @(posedge clk);
        $display("%0d bytes sent, %0d results checked over five node_index settings",
                 bytes_sent, results_seen);
        $display("status counts: direct %0d decoded %0d empty %0d mismatch %0d overflow %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4]);
        if (mismatch_count == 0)
            $display("xor_network_coding_receiver regression: pass");
        else
            $display("xor_network_coding_receiver regression: fail");
        $finish;
    end

endmodule
